### rtl/mwrms_pkg.sv
// Shared constants and types for the multichannel moving-window RMS core.
// No dependencies; imported by every module under rtl/.
package mwrms_pkg;

    localparam int CHANNELS     = 8;
    localparam int WINDOW_MAX   = 128;
    localparam int SAMPLE_BITS  = 8;
    localparam int WINDOW_RESET = 100;

    localparam int CFG_BITS  = 8;
    localparam int CHAN_BITS = 3;
    localparam int RMS_BITS  = 16;
    localparam int RMS_MAX   = (2 ** RMS_BITS) - 1;
    localparam int FRAC_BITS = 16;

    localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_BITS  = $clog2(WINDOW_MAX);
    localparam int LEN_BITS  = $clog2(WINDOW_MAX + 1);
    localparam int DEPTH     = CHANNELS * WINDOW_MAX;
    localparam int ADDR_BITS = $clog2(DEPTH);

    localparam int SQ_BITS  = 2 * SAMPLE_BITS - 1;
    localparam int SUM_BITS = $clog2(WINDOW_MAX) + SQ_BITS;

    // divider: dividend padded to an even width, two quotient bits per cycle
    localparam int DIV_W         = ((SUM_BITS + FRAC_BITS + 1) / 2) * 2;
    localparam int DIV_STEPS     = DIV_W / 2;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS + 1);

    // mean square never exceeds the largest square, so the quotient is narrow
    localparam int QBITS         = 2 * SAMPLE_BITS - 2 + FRAC_BITS + 1;
    localparam int QW            = ((QBITS + 1) / 2) * 2;
    localparam int RW            = QW / 2;
    localparam int SQRT_CNT_BITS = $clog2(RW + 1);

    localparam int IN_TDATA_BITS  = ((CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((CHAN_BITS + RMS_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                   we;
        logic [ADDR_BITS-1:0]   waddr;
        logic [SAMPLE_BITS-1:0] wdata;
        logic                   re;
        logic [ADDR_BITS-1:0]   raddr;
    } mem_req_t;

endpackage

### rtl/multichannel_window_rms_core.sv
// Multichannel moving-window RMS core: top level with control, per-channel
// positions and sums of squares. Uses mwrms_pkg, mwrms_store, mwrms_div, mwrms_sqrt.
//
// Each transfer on the slave side writes one signed sample into its channel's
// circular window and yields one master-side transfer with the window RMS in
// unsigned Q8.8. An item passes through the memory read, the squaring and the
// sum update, the serial divider (two quotient bits a cycle), a hand-off, the
// serial square root (one root bit a cycle) and the output register, which is
// loaded once it is free. One item is in work at a time, so a new item is
// accepted only after the previous result is in the output register; a finished
// result waits there while the next item is accepted. After reset and after
// every window_length write, a pass zeroes all 1024 entries of the sample
// memory, during which s_tready is low.
module multichannel_window_rms_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [mwrms_pkg::CFG_BITS-1:0]        cfg_wr_data,    // window_length
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [mwrms_pkg::IN_TDATA_BITS-1:0]   s_tdata,        // channel, sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mwrms_pkg::OUT_TDATA_BITS-1:0]  m_tdata         // out_channel, rms_q8
);
    import mwrms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SQ,
        S_UPD,
        S_DIV,
        S_SQRT,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CFG_BITS-1:0]     wlen_reg;
    logic [POS_BITS-1:0]     pos_reg [CHANNELS];
    logic [SUM_BITS-1:0]     sum_reg [CHANNELS];
    logic [CHAN_BITS-1:0]    ch_reg;
    logic [SAMPLE_BITS-1:0]  samp_reg;
    logic [ADDR_BITS-1:0]    addr_reg;
    logic [POS_BITS-1:0]     pos_use_reg;
    logic [SQ_BITS-1:0]      sq_old_reg;
    logic [SQ_BITS-1:0]      sq_new_reg;
    logic [RMS_BITS-1:0]     res_reg;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_BITS-1:0] m_tdata_reg;

    logic [LEN_BITS-1:0]     eff_len;
    logic [CHAN_BITS-1:0]    in_ch;
    logic [SAMPLE_BITS-1:0]  in_samp;
    logic                    in_ok;
    logic [CH_BITS-1:0]      in_idx;
    logic [CH_BITS-1:0]      cur_idx;
    logic [POS_BITS-1:0]     in_pos_use;
    logic [LEN_BITS-1:0]     pos_inc;
    logic [POS_BITS-1:0]     pos_adv;
    logic [SUM_BITS-1:0]     sum_upd;
    logic signed [2*SAMPLE_BITS-1:0] prod_old;
    logic signed [2*SAMPLE_BITS-1:0] prod_new;
    logic                    accept;
    logic                    out_free;

    mem_req_t                mem_req;
    logic [SAMPLE_BITS-1:0]  rd_data;
    logic                    store_busy;
    logic                    div_done;
    logic [QW-1:0]           quotient;
    logic                    sqrt_done;
    logic [RW-1:0]           root;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            eff_len = LEN_BITS'(1);
        end
        else if (32'(wlen_reg) > WINDOW_MAX)
        begin
            eff_len = LEN_BITS'(WINDOW_MAX);
        end
        else
        begin
            eff_len = LEN_BITS'(wlen_reg);
        end
    end

    assign in_ch      = s_tdata[CHAN_BITS-1:0];
    assign in_samp    = s_tdata[CHAN_BITS +: SAMPLE_BITS];
    assign in_ok      = (32'(in_ch) < CHANNELS);
    assign in_idx     = CH_BITS'(in_ch);
    assign cur_idx    = CH_BITS'(ch_reg);
    assign in_pos_use = (LEN_BITS'(pos_reg[in_idx]) >= eff_len) ? '0 : pos_reg[in_idx];
    assign pos_inc    = LEN_BITS'(pos_use_reg) + 1'b1;
    assign pos_adv    = (pos_inc >= eff_len) ? '0 : POS_BITS'(pos_inc);

    assign prod_old = $signed(rd_data) * $signed(rd_data);
    assign prod_new = $signed(samp_reg) * $signed(samp_reg);
    assign sum_upd  = sum_reg[cur_idx] - SUM_BITS'(sq_old_reg) + SUM_BITS'(sq_new_reg);

    assign s_tready = (state_reg == S_IDLE) && !store_busy;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        mem_req.we    = (state_reg == S_UPD);
        mem_req.waddr = addr_reg;
        mem_req.wdata = samp_reg;
        mem_req.re    = (state_reg == S_READ);
        mem_req.raddr = addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wlen_reg     <= CFG_BITS'(WINDOW_RESET);
            ch_reg       <= '0;
            samp_reg     <= '0;
            addr_reg     <= '0;
            pos_use_reg  <= '0;
            sq_old_reg   <= '0;
            sq_new_reg   <= '0;
            res_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (m_tready && (state_reg != S_EMIT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                wlen_reg <= cfg_wr_data;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    pos_reg[i] <= '0;
                    sum_reg[i] <= '0;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ch_reg      <= in_ch;
                        samp_reg    <= in_samp;
                        pos_use_reg <= in_pos_use;
                        addr_reg    <= ADDR_BITS'(32'(in_idx) * WINDOW_MAX)
                                       + ADDR_BITS'(in_pos_use);
                        if (in_ok)
                        begin
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            res_reg   <= '0;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    sq_old_reg <= SQ_BITS'(prod_old);
                    sq_new_reg <= SQ_BITS'(prod_new);
                    state_reg  <= S_UPD;
                end
                S_UPD:
                begin
                    sum_reg[cur_idx] <= sum_upd;
                    pos_reg[cur_idx] <= pos_adv;
                    state_reg        <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        res_reg   <= (root > RW'(RMS_MAX)) ? RMS_BITS'(RMS_MAX)
                                                           : RMS_BITS'(root);
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= OUT_TDATA_BITS'({res_reg, ch_reg});
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    mwrms_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr_start (cfg_wr_en),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .busy      (store_busy)
    );

    mwrms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_UPD),
        .dividend (DIV_W'({sum_upd, {FRAC_BITS{1'b0}}})),
        .divisor  (eff_len),
        .done     (div_done),
        .quotient (quotient)
    );

    mwrms_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_done),
        .radicand (quotient),
        .done     (sqrt_done),
        .root     (root)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/mwrms_store.sv
// Sample window memory for all channels, with registered read and a
// zero-fill sweep after reset or on request. Depends on mwrms_pkg.
module mwrms_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            clr_start,
    input  mwrms_pkg::mem_req_t             mem_req,
    output logic [mwrms_pkg::SAMPLE_BITS-1:0] rd_data,
    output logic                            busy
);
    import mwrms_pkg::*;

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [ADDR_BITS-1:0]   clr_cnt_reg;
    logic [ADDR_BITS-1:0]   clr_cnt_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        busy_next    = busy_reg;
        if (clr_start)
        begin
            clr_cnt_next = '0;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_BITS'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (busy_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = mem_req.we;
            wr_addr = mem_req.waddr;
            wr_data = mem_req.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_req.re)
        begin
            rd_data_reg <= mem[mem_req.raddr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

### rtl/mwrms_div.sv
// Serial restoring divider, two quotient bits per cycle.
// Divides the scaled sum of squares by the window length. Depends on mwrms_pkg.
module mwrms_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mwrms_pkg::DIV_W-1:0]   dividend,
    input  logic [mwrms_pkg::LEN_BITS-1:0] divisor,
    output logic                          done,
    output logic [mwrms_pkg::QW-1:0]      quotient
);
    import mwrms_pkg::*;

    logic [LEN_BITS-1:0]     rem_reg;
    logic [DIV_W-1:0]        dq_reg;
    logic [LEN_BITS-1:0]     dvs_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic [LEN_BITS-1:0]     rem_mid;
    logic [LEN_BITS-1:0]     rem_next;
    logic                    qbit_hi;
    logic                    qbit_lo;
    logic [LEN_BITS:0]       t_hi;
    logic [LEN_BITS:0]       t_lo;

    always_comb
    begin
        t_hi    = {rem_reg, dq_reg[DIV_W-1]};
        qbit_hi = (t_hi >= {1'b0, dvs_reg});
        rem_mid = qbit_hi ? LEN_BITS'(t_hi - {1'b0, dvs_reg}) : LEN_BITS'(t_hi);
        t_lo    = {rem_mid, dq_reg[DIV_W-2]};
        qbit_lo = (t_lo >= {1'b0, dvs_reg});
        rem_next = qbit_lo ? LEN_BITS'(t_lo - {1'b0, dvs_reg}) : LEN_BITS'(t_lo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dq_reg   <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                dq_reg   <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= DIV_CNT_BITS'(DIV_STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                dq_reg  <= {dq_reg[DIV_W-3:0], qbit_hi, qbit_lo};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = QW'(dq_reg);

endmodule

### rtl/mwrms_sqrt.sv
// Serial integer square root, one root bit per cycle (two radicand bits in).
// Depends on mwrms_pkg.
module mwrms_sqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [mwrms_pkg::QW-1:0] radicand,
    output logic                     done,
    output logic [mwrms_pkg::RW-1:0] root
);
    import mwrms_pkg::*;

    logic [RW+1:0]            rem_reg;
    logic [QW-1:0]            q_reg;
    logic [RW-1:0]            root_reg;
    logic [SQRT_CNT_BITS-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [RW+3:0]            t;
    logic [RW+3:0]            trial;
    logic                     rbit;

    always_comb
    begin
        t     = {rem_reg, q_reg[QW-1 -: 2]};
        trial = (RW + 4)'({root_reg, 2'b01});
        rbit  = (t >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            q_reg    <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                q_reg    <= radicand;
                root_reg <= '0;
                cnt_reg  <= SQRT_CNT_BITS'(RW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= rbit ? (RW + 2)'(t - trial) : (RW + 2)'(t);
                q_reg    <= {q_reg[QW-3:0], 2'b00};
                root_reg <= {root_reg[RW-2:0], rbit};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == SQRT_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### test/multichannel_window_rms_core_tb.sv
// Self-checking testbench for multichannel_window_rms_core: streams samples, predicts
// each channel's windowed RMS in Q8.8 and compares every master-side transfer.
// Depends on mwrms_pkg and the core RTL under rtl/.
module multichannel_window_rms_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mwrms_pkg::*;

    typedef struct packed {
        logic [CHAN_BITS-1:0] channel;
        logic [RMS_BITS-1:0]  rms_q8;
    } rms_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0]       cfg_wr_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;   // channel, sample
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;        // out_channel, rms_q8

    // predictor state
    logic signed [SAMPLE_BITS-1:0] win_store [CHANNELS][WINDOW_MAX];
    int unsigned                   write_pos [CHANNELS];
    longint                        energy [CHANNELS];
    logic [CFG_BITS-1:0]           window_len;

    rms_result_t expected_rms_q [$];
    int          error_count = 0;
    int          src_idle_pct = 0;
    int          sink_idle_pct = 0;

    multichannel_window_rms_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic void clear_windows();
        for (int c = 0; c < CHANNELS; c++)
        begin
            write_pos[c] = 0;
            energy[c] = 0;
            for (int i = 0; i < WINDOW_MAX; i++)
                win_store[c][i] = '0;
        end
    endfunction

    function automatic rms_result_t predict_window_rms(logic [CHAN_BITS-1:0] ch,
                                                       logic signed [SAMPLE_BITS-1:0] smp);
        rms_result_t       r;
        int unsigned       len;
        int unsigned       slot;
        int                old_v;
        int                new_v;
        longint unsigned   mean_sq;
        longint unsigned   root;
        longint unsigned   trial;
        r.channel = ch;
        r.rms_q8 = '0;
        len = (window_len == 0) ? 1 : ((window_len > WINDOW_MAX) ? WINDOW_MAX : window_len);
        if (ch < CHANNELS)
        begin
            slot = write_pos[ch];
            if (slot >= len)
                slot = 0;
            old_v = win_store[ch][slot];
            new_v = smp;
            energy[ch] = energy[ch] - old_v * old_v + new_v * new_v;
            win_store[ch][slot] = smp;
            slot++;
            if (slot >= len)
                slot = 0;
            write_pos[ch] = slot;
            mean_sq = (longint'(energy[ch]) << 16) / len;
            root = 0;
            for (int b = 20; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= mean_sq)
                    root = trial;
            end
            r.rms_q8 = (root > RMS_MAX) ? RMS_MAX[RMS_BITS-1:0] : root[RMS_BITS-1:0];
        end
        return r;
    endfunction

    task automatic send_sample(input logic [CHAN_BITS-1:0] ch,
                               input logic signed [SAMPLE_BITS-1:0] smp);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_TDATA_BITS - CHAN_BITS - SAMPLE_BITS){1'b0}}, smp, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_rms_q = {expected_rms_q, predict_window_rms(ch, smp)};
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_rms_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_window_length(input logic [CFG_BITS-1:0] value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        window_len = value;
        clear_windows();
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        rms_result_t got;
        rms_result_t exp_r;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.channel = m_tdata[CHAN_BITS-1:0];
                got.rms_q8 = m_tdata[CHAN_BITS +: RMS_BITS];
                if (expected_rms_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected transfer, actual channel %0d rms %0d",
                             $time, got.channel, got.rms_q8);
                end
                else
                begin
                    exp_r = expected_rms_q.pop_front();
                    if (got.channel !== exp_r.channel)
                    begin
                        error_count++;
                        $display("%0t: out_channel expected %0d actual %0d",
                                 $time, exp_r.channel, got.channel);
                    end
                    if (got.rms_q8 !== exp_r.rms_q8)
                    begin
                        error_count++;
                        $display("%0t: rms_q8 (ch %0d) expected %0d actual %0d",
                                 $time, exp_r.channel, exp_r.rms_q8, got.rms_q8);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic test_default_window();
        send_sample(3'd0, 8'sd127);
        send_sample(3'd7, -8'sd128);
        send_sample(3'd3, 8'sd0);
        send_sample(3'd5, -8'sd1);
        send_sample(3'd1, 8'sd1);
        send_sample(3'd2, 8'sd64);
        send_sample(3'd4, -8'sd64);
        send_sample(3'd6, 8'sd85);
        send_sample(3'd7, -8'sd86);
        send_sample(3'd0, 8'sd127);
    endtask

    task automatic test_length_extremes();
        write_window_length(8'd1);
        send_sample(3'd2, -8'sd128);
        send_sample(3'd2, -8'sd128);
        send_sample(3'd2, 8'sd127);
        // zero acts as a one-sample window
        write_window_length(8'd0);
        send_sample(3'd1, 8'sd127);
        send_sample(3'd1, -8'sd128);
        // above the maximum clamps to the maximum
        write_window_length(8'd255);
        send_sample(3'd6, -8'sd128);
        send_sample(3'd6, 8'sd127);
        write_window_length(WINDOW_MAX[CFG_BITS-1:0]);
        send_sample(3'd0, -8'sd128);
        send_sample(3'd7, 8'sd127);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input logic [CFG_BITS-1:0] len_value,
                                       input int chan_hi, input int n_items);
        logic [CHAN_BITS-1:0]          ch;
        logic signed [SAMPLE_BITS-1:0] smp;
        write_window_length(len_value);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        for (int n = 0; n < n_items; n++)
        begin
            ch = CHAN_BITS'($urandom_range(chan_hi, 0));
            if ($urandom_range(7) == 0)
                smp = $urandom_range(1) ? 8'sd127 : -8'sd128;
            else
                smp = SAMPLE_BITS'($urandom_range(255));
            send_sample(ch, smp);
        end
    endtask

    initial
    begin
        window_len = WINDOW_RESET[CFG_BITS-1:0];
        clear_windows();
        src_idle_pct = 29;
        sink_idle_pct = 70;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_default_window();
        test_length_extremes();
        test_random_traffic(29, 70, CFG_BITS'($urandom_range(16, 1)), CHANNELS - 1, 550);
        test_random_traffic(70, 29, CFG_BITS'($urandom_range(255, 129)), 1, 550);
        test_random_traffic(0, 0, CFG_BITS'($urandom_range(127, 17)), 3, 550);
        wait_drained();
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("status: fail");
        $finish;
    end

endmodule

### multichannel_window_rms_core.f
rtl/mwrms_pkg.sv
rtl/mwrms_store.sv
rtl/mwrms_div.sv
rtl/mwrms_sqrt.sv
rtl/multichannel_window_rms_core.sv
test/multichannel_window_rms_core_tb.sv
